// ===== hw/rtl/assert_macros.svh =====
// assertion macros used by the checker file wgpd_checker.sv
// no dependencies
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, held off during reset
`define WGPD_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("same-cycle implication failed");

// next-cycle implication, held off during reset
`define WGPD_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("next-cycle implication failed");

// next-cycle implication that also covers reset cycles
`define WGPD_ASSERT_NXT_RAW(lbl, clk, ante, cons) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("next-cycle implication failed");

`endif

// ===== hw/rtl/wgpd_pkg.sv =====
// types, codes and sizes for the watermark gated priority dispatch block
// no dependencies
`timescale 1ns / 1ps
`default_nettype none
package wgpd_pkg;

  localparam int QUEUE_DEPTH = 16;

  localparam int ID_W   = 22;
  localparam int PRIO_W = 8;
  localparam int CNT_W  = 10;

  // request op codes
  localparam logic [1:0] OP_ARRIVE   = 2'd0;
  localparam logic [1:0] OP_DISPATCH = 2'd1;
  localparam logic [1:0] OP_TOGGLE   = 2'd2;
  localparam logic [1:0] OP_WITHDRAW = 2'd3;

  // result kinds
  localparam logic [1:0] KIND_ADMIT    = 2'd0;
  localparam logic [1:0] KIND_WITHDRAW = 2'd1;
  localparam logic [1:0] KIND_REJECT   = 2'd2;

  // configuration register indexes
  localparam logic CFG_UPPER_MARK = 1'b0;
  localparam logic CFG_LOWER_MARK = 1'b1;

  typedef struct packed {
    logic [1:0]        op;
    logic              cls;
    logic [ID_W-1:0]   entry_id;
    logic [PRIO_W-1:0] prio;
    logic [CNT_W-1:0]  downstream_count;
  } in_req_t;

  typedef struct packed {
    logic [1:0]        kind;
    logic              out_cls;
    logic [ID_W-1:0]   out_id;
    logic [PRIO_W-1:0] out_prio;
  } out_res_t;

  typedef enum logic [1:0] {
    Q_IDLE,
    Q_INSERT,
    Q_POP,
    Q_WITHDRAW
  } q_op_t;

  typedef struct packed {
    logic              valid;
    logic [ID_W-1:0]   id;
    logic [PRIO_W-1:0] prio;
  } entry_t;

  typedef struct packed {
    q_op_t             op;
    logic [ID_W-1:0]   id;
    logic [PRIO_W-1:0] prio;
  } q_cmd_t;

  // left-to-right link between neighboring cells
  typedef struct packed {
    entry_t ent;
    logic   ge;
    logic   found;
    entry_t sel;
  } fwd_link_t;

  typedef struct packed {
    entry_t head;
    logic   full;
    logic   found;
    entry_t sel;
  } q_status_t;

endpackage
`default_nettype wire

// ===== hw/rtl/wgpd_cell.sv =====
// one slot of the sorted queue chain, talks only to its two neighbors and the shared command
// depends on wgpd_pkg
`timescale 1ns / 1ps
`default_nettype none
module wgpd_cell (
  input  logic                clk,
  input  logic                rst_n,
  input  wgpd_pkg::q_cmd_t    cmd,
  input  wgpd_pkg::fwd_link_t fwd_in,
  input  wgpd_pkg::entry_t    right_ent,
  output wgpd_pkg::fwd_link_t fwd_out
);
  import wgpd_pkg::*;

  logic              valid_r;
  logic [ID_W-1:0]   id_r;
  logic [PRIO_W-1:0] prio_r;
  entry_t            cur;
  entry_t            ent_nxt;
  logic              ge;
  logic              match;

  assign cur   = '{valid: valid_r, id: id_r, prio: prio_r};
  assign ge    = valid_r && (prio_r >= cmd.prio);
  assign match = valid_r && (id_r == cmd.id);

  always_comb begin
    fwd_out.ent   = cur;
    fwd_out.ge    = ge;
    fwd_out.found = fwd_in.found | match;
    // first match along the chain is the best-ranked one
    fwd_out.sel   = fwd_in.found ? fwd_in.sel : cur;
  end

  always_comb begin
    ent_nxt = cur;
    case (cmd.op)
      Q_INSERT: begin
        // entries at or above the new priority stay, the rest move right
        if (!ge) begin
          if (fwd_in.ge) begin
            ent_nxt = '{valid: 1'b1, id: cmd.id, prio: cmd.prio};
          end else begin
            ent_nxt = fwd_in.ent;
          end
        end
      end
      Q_POP: begin
        ent_nxt = right_ent;
      end
      Q_WITHDRAW: begin
        if (fwd_out.found) begin
          ent_nxt = right_ent;
        end
      end
      default: begin
        ent_nxt = cur;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= ent_nxt.valid;
    end
  end

  always_ff @(posedge clk) begin
    id_r   <= ent_nxt.id;
    prio_r <= ent_nxt.prio;
  end

endmodule
`default_nettype wire

// ===== hw/rtl/wgpd_queue.sv =====
// one class queue: a chain of cells kept sorted, best entry in the first cell
// depends on wgpd_pkg and wgpd_cell
`timescale 1ns / 1ps
`default_nettype none
module wgpd_queue (
  input  logic                clk,
  input  logic                rst_n,
  input  wgpd_pkg::q_cmd_t    cmd,
  output wgpd_pkg::q_status_t status
);
  import wgpd_pkg::*;

  fwd_link_t link [QUEUE_DEPTH+1];
  entry_t    rent [QUEUE_DEPTH];

  always_comb begin
    link[0]    = '0;
    link[0].ge = 1'b1;
  end

  genvar g;
  generate
    for (g = 0; g < QUEUE_DEPTH; g++) begin : g_cell
      if (g == QUEUE_DEPTH - 1) begin : g_last
        assign rent[g] = '0;
      end else begin : g_mid
        assign rent[g] = link[g+2].ent;
      end

      wgpd_cell u_cell (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .fwd_in    (link[g]),
        .right_ent (rent[g]),
        .fwd_out   (link[g+1])
      );
    end
  endgenerate

  // the chain stays packed, so the last cell tells full
  always_comb begin
    status.head  = link[1].ent;
    status.full  = link[QUEUE_DEPTH].ent.valid;
    status.found = link[QUEUE_DEPTH].found;
    status.sel   = link[QUEUE_DEPTH].sel;
  end

endmodule
`default_nettype wire

// ===== hw/rtl/watermark_gated_priority_dispatch.sv =====
// watermark gated priority dispatch, top level
// depends on wgpd_pkg and wgpd_queue
//
// Requests enter on in_data with in_valid/in_stall; results leave on out_data
// with out_valid/out_stall. Each request is one of arrive, dispatch, toggle
// enable or withdraw for one of two classes. A request gives at most one
// result: an admitted entry, a withdrawn entry or a rejected arrival.
// Every request finishes in the cycle it is accepted: each class queue is a
// chain of cells kept sorted, which insert, pop and remove by id. A result
// shows on out_data in the cycle after its request.
// One request per cycle is taken while the result register is empty or
// being drained; while a result waits under out_stall, in_stall is raised.
// The user must write the marks on cfg_we/cfg_idx/cfg_wdata only while no
// request is in flight; the block itself does not enforce this.
// Synchronous reset empties both queues, opens both class gates, disables
// dispatch and sets the marks to upper 8 and lower 2; in_stall is low at
// the first cycle after reset.
`timescale 1ns / 1ps
`default_nettype none
module watermark_gated_priority_dispatch (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  wgpd_pkg::in_req_t              in_data,
  output logic                           out_valid,
  input  logic                           out_stall,
  output wgpd_pkg::out_res_t             out_data,
  input  logic                           cfg_we,
  input  logic                           cfg_idx,
  input  logic [wgpd_pkg::CNT_W-1:0]     cfg_wdata
);
  import wgpd_pkg::*;

  logic [CNT_W-1:0] upper_r;
  logic [CNT_W-1:0] lower_r;
  logic [1:0]       gate_r;
  logic [1:0]       gate_nxt;
  logic             en_r;
  logic             en_nxt;
  logic             out_valid_r;
  out_res_t         out_data_r;

  q_cmd_t    cmd [2];
  q_status_t st  [2];
  q_status_t st_sel;
  logic      in_acc;
  logic      res_valid;
  out_res_t  res;
  logic      rel;

  assign in_stall  = out_valid_r && out_stall;
  assign in_acc    = in_valid && !in_stall;
  assign st_sel    = st[in_data.cls];
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  wgpd_queue u_q0 (
    .clk    (clk),
    .rst_n  (rst_n),
    .cmd    (cmd[0]),
    .status (st[0])
  );

  wgpd_queue u_q1 (
    .clk    (clk),
    .rst_n  (rst_n),
    .cmd    (cmd[1]),
    .status (st[1])
  );

  always_comb begin
    cmd[0]    = '{op: Q_IDLE, id: in_data.entry_id, prio: in_data.prio};
    cmd[1]    = '{op: Q_IDLE, id: in_data.entry_id, prio: in_data.prio};
    res_valid = 1'b0;
    res       = '{kind: KIND_REJECT, out_cls: in_data.cls,
                  out_id: in_data.entry_id, out_prio: in_data.prio};
    gate_nxt  = gate_r;
    en_nxt    = en_r;
    rel       = 1'b0;
    if (in_acc) begin
      case (in_data.op)
        OP_ARRIVE: begin
          if (st_sel.full) begin
            res_valid = 1'b1;
          end else begin
            cmd[in_data.cls].op = Q_INSERT;
          end
        end
        OP_DISPATCH: begin
          if (en_r && st_sel.head.valid) begin
            if (in_data.downstream_count <= lower_r) begin
              rel                   = 1'b1;
              gate_nxt[in_data.cls] = 1'b1;
            end else if (in_data.downstream_count < upper_r && gate_r[in_data.cls]) begin
              rel = 1'b1;
            end
            if (rel) begin
              cmd[in_data.cls].op = Q_POP;
              res_valid           = 1'b1;
              res.kind            = KIND_ADMIT;
              res.out_id          = st_sel.head.id;
              res.out_prio        = st_sel.head.prio;
            end
            // gate closes after the release decision
            if (in_data.downstream_count >= upper_r) begin
              gate_nxt[in_data.cls] = 1'b0;
            end
          end
        end
        OP_TOGGLE: begin
          en_nxt = !en_r;
        end
        OP_WITHDRAW: begin
          cmd[in_data.cls].op = Q_WITHDRAW;
          if (st_sel.found) begin
            res_valid    = 1'b1;
            res.kind     = KIND_WITHDRAW;
            res.out_id   = st_sel.sel.id;
            res.out_prio = st_sel.sel.prio;
          end
        end
        default: begin
          en_nxt = en_r;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      upper_r     <= CNT_W'(8);
      lower_r     <= CNT_W'(2);
      gate_r      <= 2'b11;
      en_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_idx)
          CFG_UPPER_MARK: upper_r <= cfg_wdata;
          CFG_LOWER_MARK: lower_r <= cfg_wdata;
          default:        upper_r <= upper_r;
        endcase
      end
      gate_r <= gate_nxt;
      en_r   <= en_nxt;
      if (in_acc && res_valid) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc && res_valid) begin
      out_data_r <= res;
    end
  end

endmodule
`default_nettype wire

// ===== hw/rtl/wgpd_checker.sv =====
// port-level checker for the watermark gated priority dispatch block, with bind
// depends on wgpd_pkg and assert_macros.svh
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
module wgpd_checker (
  input logic                clk,
  input logic                rst_n,
  input logic                in_valid,
  input logic                in_stall,
  input wgpd_pkg::in_req_t   in_data,
  input logic                out_valid,
  input logic                out_stall,
  input wgpd_pkg::out_res_t  out_data
);
  import wgpd_pkg::*;

  logic kind_ok;

  assign kind_ok = (out_data.kind == KIND_ADMIT) || (out_data.kind == KIND_WITHDRAW) ||
                   (out_data.kind == KIND_REJECT);

  // a held result keeps its payload
  `WGPD_ASSERT_NXT(a_out_hold, clk, rst_n, out_valid && out_stall, out_valid && $stable(out_data))

  // requests are held back only by a waiting result
  `WGPD_ASSERT_IMP(a_stall_cause, clk, rst_n, in_stall, out_valid && out_stall)

  // a toggle request never produces a result
  `WGPD_ASSERT_NXT(a_toggle_quiet, clk, rst_n, in_valid && !in_stall && in_data.op == OP_TOGGLE, !out_valid)

  // result kinds stay within the three defined codes
  `WGPD_ASSERT_IMP(a_kind_code, clk, rst_n, out_valid, kind_ok)

  // reset empties the result register
  `WGPD_ASSERT_NXT_RAW(a_reset_empty, clk, !rst_n, !out_valid)

endmodule

bind watermark_gated_priority_dispatch wgpd_checker u_wgpd_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .in_data   (in_data),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);
`default_nettype wire

// ===== tb/sv/wgpd_dispatch_checker.sv =====
`timescale 1ns / 1ps
// scoreboard for watermark_gated_priority_dispatch: tracks both class queues,
// the gates, the enable and the marks, and checks every result in order
// depends on wgpd_pkg
module wgpd_dispatch_checker (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  input  logic                       in_stall,
  input  wgpd_pkg::in_req_t          in_data,
  input  logic                       out_valid,
  input  logic                       out_stall,
  input  wgpd_pkg::out_res_t         out_data,
  input  logic                       cfg_we,
  input  logic                       cfg_idx,
  input  logic [wgpd_pkg::CNT_W-1:0] cfg_wdata,
  output int                         mismatch_count,
  output int                         pending_count
);
  import wgpd_pkg::*;

  // entries per class, kept in arrival order, oldest at index 0
  logic [ID_W-1:0]   slot_id   [2][QUEUE_DEPTH];
  logic [PRIO_W-1:0] slot_prio [2][QUEUE_DEPTH];
  int                fill      [2];
  logic              gate_open [2];
  logic              dispatch_on;
  logic [CNT_W-1:0]  upper_mark;
  logic [CNT_W-1:0]  lower_mark;

  out_res_t expected_results [$];
  out_res_t want;
  string    bad_fields;
  int       errors = 0;

  function automatic out_res_t make_result(input logic [1:0] kind, input logic c,
                                           input logic [ID_W-1:0] id,
                                           input logic [PRIO_W-1:0] prio);
    out_res_t res;
    res.kind     = kind;
    res.out_cls  = c;
    res.out_id   = id;
    res.out_prio = prio;
    return res;
  endfunction

  task automatic add_expected(input out_res_t res);
    expected_results = {expected_results, res};
  endtask

  // close the gap left by slot k
  task automatic drop_slot(input int c, input int k);
    for (int i = k; i + 1 < fill[c]; i++) begin
      slot_id[c][i]   = slot_id[c][i + 1];
      slot_prio[c][i] = slot_prio[c][i + 1];
    end
    fill[c]--;
  endtask

  task automatic predict_request(input in_req_t r);
    int c;
    int k;
    bit grant;
    c     = int'(r.cls);
    k     = -1;
    grant = 1'b0;
    case (r.op)
      OP_ARRIVE: begin
        if (fill[c] >= QUEUE_DEPTH) begin
          add_expected(make_result(KIND_REJECT, r.cls, r.entry_id, r.prio));
        end else begin
          slot_id[c][fill[c]]   = r.entry_id;
          slot_prio[c][fill[c]] = r.prio;
          fill[c]++;
        end
      end
      OP_DISPATCH: begin
        if (dispatch_on && fill[c] != 0) begin
          if (r.downstream_count <= lower_mark) begin
            grant        = 1'b1;
            gate_open[c] = 1'b1;
          end else if (r.downstream_count < upper_mark && gate_open[c]) begin
            grant = 1'b1;
          end
          if (grant) begin
            // strict compare keeps the oldest among equal priorities
            k = 0;
            for (int i = 1; i < fill[c]; i++) begin
              if (slot_prio[c][i] > slot_prio[c][k]) k = i;
            end
            add_expected(make_result(KIND_ADMIT, r.cls, slot_id[c][k], slot_prio[c][k]));
            drop_slot(c, k);
          end
          if (r.downstream_count >= upper_mark) gate_open[c] = 1'b0;
        end
      end
      OP_TOGGLE: begin
        dispatch_on = !dispatch_on;
      end
      default: begin
        for (int i = 0; i < fill[c]; i++) begin
          if (slot_id[c][i] == r.entry_id && (k < 0 || slot_prio[c][i] > slot_prio[c][k]))
            k = i;
        end
        if (k >= 0) begin
          add_expected(make_result(KIND_WITHDRAW, r.cls, slot_id[c][k], slot_prio[c][k]));
          drop_slot(c, k);
        end
      end
    endcase
  endtask

  task automatic log_mismatch(input string why, input out_res_t exp_res, input out_res_t got);
    errors++;
    if (errors <= 10)
      $display("dispatch check: %s: expected kind %0d cls %0d id %h prio %h, got kind %0d cls %0d id %h prio %h",
               why, exp_res.kind, exp_res.out_cls, exp_res.out_id, exp_res.out_prio,
               got.kind, got.out_cls, got.out_id, got.out_prio);
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      fill[0]      = 0;
      fill[1]      = 0;
      gate_open[0] = 1'b1;
      gate_open[1] = 1'b1;
      dispatch_on  = 1'b0;
      upper_mark   = 10'd8;
      lower_mark   = 10'd2;
      expected_results.delete();
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_results.size() == 0) begin
          log_mismatch("result with nothing pending", '0, out_data);
        end else begin
          want       = expected_results.pop_front();
          bad_fields = "";
          if (out_data.kind !== want.kind)         bad_fields = {bad_fields, " kind"};
          if (out_data.out_cls !== want.out_cls)   bad_fields = {bad_fields, " cls"};
          if (out_data.out_id !== want.out_id)     bad_fields = {bad_fields, " id"};
          if (out_data.out_prio !== want.out_prio) bad_fields = {bad_fields, " prio"};
          if (bad_fields != "") log_mismatch({"wrong", bad_fields}, want, out_data);
        end
      end
      if (cfg_we) begin
        if (cfg_idx == CFG_UPPER_MARK) upper_mark = cfg_wdata;
        else lower_mark = cfg_wdata;
      end
      // a request's result can only show from the next edge on
      if (in_valid && !in_stall) predict_request(in_data);
    end
    mismatch_count <= errors;
    pending_count  <= expected_results.size();
  end

endmodule

// ===== tb/sv/watermark_gated_priority_dispatch_tb.sv =====
`timescale 1ns / 1ps
// stimulus and verdict for watermark_gated_priority_dispatch
// depends on wgpd_pkg, the block and wgpd_dispatch_checker
module watermark_gated_priority_dispatch_tb;
  import wgpd_pkg::*;

  localparam int HOLD_CYCLES    = 300;
  localparam int WATCHDOG_LIMIT = 5000;
  localparam int PHASE_ITEMS    = 100;

  logic             clk       = 1'b0;
  logic             rst_n     = 1'b0;
  logic             in_valid  = 1'b0;
  logic             in_stall;
  in_req_t          in_data   = '0;
  logic             out_valid;
  logic             out_stall = 1'b0;
  out_res_t         out_data;
  logic             cfg_we    = 1'b0;
  logic             cfg_idx   = 1'b0;
  logic [CNT_W-1:0] cfg_wdata = '0;

  int mismatches;
  int pending;
  int quiet_cycles  = 0;
  int send_idle_pct = 0;
  int stall_pct     = 0;
  int arrive_pct    = 45;
  logic hold_off_req = 1'b0;

  // what the stimulus knows of the block, to aim requests
  logic             enable_shadow = 1'b0;
  logic [CNT_W-1:0] upper_shadow  = 10'd8;
  logic [CNT_W-1:0] lower_shadow  = 10'd2;
  logic [ID_W-1:0]  recent_ids [$];

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  watermark_gated_priority_dispatch dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_wdata (cfg_wdata)
  );

  wgpd_dispatch_checker checker_i (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_data        (in_data),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_data       (out_data),
    .cfg_we         (cfg_we),
    .cfg_idx        (cfg_idx),
    .cfg_wdata      (cfg_wdata),
    .mismatch_count (mismatches),
    .pending_count  (pending)
  );

  // receiver: random stall, or one long hold-off when asked
  initial begin : recv_stall
    forever begin
      @(posedge clk);
      if (hold_off_req) begin
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_off_req <= 1'b0;
      end else begin
        out_stall <= ($urandom_range(99) < stall_pct);
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("watermark_gated_priority_dispatch_tb: FAIL");
      $finish;
    end
  end

  task automatic push_req(input in_req_t r);
    if (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
    end
    in_valid <= 1'b1;
    in_data  <= r;
    do @(posedge clk); while (in_stall);
    if (r.op == OP_TOGGLE) enable_shadow = !enable_shadow;
    if (r.op == OP_ARRIVE) begin
      recent_ids = {recent_ids, r.entry_id};
      if (recent_ids.size() > 32) void'(recent_ids.pop_front());
    end
  endtask

  task automatic issue(input logic [1:0] op, input logic c, input logic [ID_W-1:0] id,
                       input logic [PRIO_W-1:0] prio, input logic [CNT_W-1:0] occ);
    in_req_t r;
    r.op               = op;
    r.cls              = c;
    r.entry_id         = id;
    r.prio             = prio;
    r.downstream_count = occ;
    push_req(r);
  endtask

  // hold the sender until every result is back, then let the block settle
  task automatic drain_results();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (4) @(posedge clk);
  endtask

  task automatic set_marks(input logic [CNT_W-1:0] upper, input logic [CNT_W-1:0] lower);
    cfg_we    <= 1'b1;
    cfg_idx   <= CFG_UPPER_MARK;
    cfg_wdata <= upper;
    @(posedge clk);
    cfg_idx   <= CFG_LOWER_MARK;
    cfg_wdata <= lower;
    @(posedge clk);
    cfg_we       <= 1'b0;
    upper_shadow = upper;
    lower_shadow = lower;
  endtask

  function automatic in_req_t next_random_request();
    in_req_t r;
    int roll;
    roll               = $urandom_range(99);
    r.cls              = 1'($urandom_range(1));
    r.entry_id         = ID_W'($urandom);
    r.prio             = PRIO_W'($urandom);
    r.downstream_count = CNT_W'($urandom);
    if (roll < 4 || (!enable_shadow && roll < 30)) begin
      r.op = OP_TOGGLE;
    end else if (roll < 4 + arrive_pct) begin
      r.op = OP_ARRIVE;
      // repeated ids and tied priorities exercise withdraw and ordering
      if (recent_ids.size() != 0 && $urandom_range(4) == 0)
        r.entry_id = recent_ids[$urandom_range(recent_ids.size() - 1)];
      if ($urandom_range(1)) r.prio = PRIO_W'($urandom_range(3) * 85);
    end else if (roll < 4 + arrive_pct + (96 - arrive_pct) * 2 / 3) begin
      r.op = OP_DISPATCH;
      case ($urandom_range(9))
        0, 1, 2, 3: r.downstream_count = CNT_W'($urandom_range(lower_shadow, 0));
        4, 5, 6: begin
          if (upper_shadow > lower_shadow + 1)
            r.downstream_count = CNT_W'($urandom_range(upper_shadow - 1, lower_shadow + 1));
        end
        7, 8: r.downstream_count = CNT_W'($urandom_range(1023, upper_shadow));
        default: ;
      endcase
    end else begin
      r.op = OP_WITHDRAW;
      if (recent_ids.size() != 0 && $urandom_range(3) != 0)
        r.entry_id = recent_ids[$urandom_range(recent_ids.size() - 1)];
    end
    return r;
  endfunction

  initial begin : stimulus
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed part on the reset marks, upper 8 and lower 2
    issue(OP_DISPATCH, 1'b0, 22'h0, 8'h0, 10'd0);          // disabled and empty
    issue(OP_TOGGLE, 1'b1, 22'h3fffff, 8'hff, 10'h3ff);
    issue(OP_DISPATCH, 1'b0, 22'h0, 8'h0, 10'd0);          // enabled but empty
    issue(OP_ARRIVE, 1'b0, 22'h0, 8'h00, 10'h3ff);
    issue(OP_ARRIVE, 1'b0, 22'h3fffff, 8'hff, 10'd0);
    issue(OP_ARRIVE, 1'b0, 22'h000005, 8'hff, 10'd0);      // ties with the older one
    issue(OP_ARRIVE, 1'b1, 22'h2aaaaa, 8'h80, 10'd0);
    issue(OP_WITHDRAW, 1'b1, 22'h155555, 8'h0, 10'd0);     // absent id
    issue(OP_WITHDRAW, 1'b1, 22'h0, 8'h0, 10'd0);          // id lives in the other class
    issue(OP_DISPATCH, 1'b0, 22'h0, 8'h0, 10'd0);
    issue(OP_DISPATCH, 1'b0, 22'h0, 8'h0, 10'h3ff);        // held, gate closes
    issue(OP_DISPATCH, 1'b0, 22'h0, 8'h0, 10'd5);          // between marks, gate closed
    issue(OP_DISPATCH, 1'b0, 22'h0, 8'h0, 10'd2);          // at low mark, gate reopens
    issue(OP_DISPATCH, 1'b0, 22'h0, 8'h0, 10'd7);          // between marks, gate open
    issue(OP_ARRIVE, 1'b1, 22'h2aaaaa, 8'h10, 10'd0);
    issue(OP_WITHDRAW, 1'b1, 22'h2aaaaa, 8'h0, 10'd0);     // takes the higher priority copy
    issue(OP_DISPATCH, 1'b1, 22'h0, 8'h0, 10'd8);          // at high mark
    issue(OP_TOGGLE, 1'b0, 22'h0, 8'h0, 10'd0);
    issue(OP_DISPATCH, 1'b1, 22'h0, 8'h0, 10'd0);          // disabled again
    issue(OP_TOGGLE, 1'b0, 22'h0, 8'h0, 10'd0);
    issue(OP_DISPATCH, 1'b1, 22'h0, 8'h0, 10'd0);
    drain_results();

    for (int phase = 0; phase < 5; phase++) begin
      case (phase)
        0: begin
          send_idle_pct = 0;
          stall_pct     = 0;
          set_marks(10'd8, 10'd2);
        end
        1: begin
          send_idle_pct = 52;
          stall_pct     = 0;
          set_marks(10'd1023, 10'd0);
        end
        2: begin
          send_idle_pct = 0;
          stall_pct     = 52;
          set_marks(10'd5, 10'd12);                          // crossed marks
        end
        3: begin
          send_idle_pct = 18;
          stall_pct     = 18;
          set_marks(10'd0, 10'd0);
        end
        default: begin
          send_idle_pct = 0;
          stall_pct     = 0;
          set_marks(10'd1023, 10'd1023);
        end
      endcase
      if (phase == 0) begin
        // receiver holds off while one class overflows, so the reject result
        // sits in the output register and the input backs up
        hold_off_req <= 1'b1;
        repeat (24) issue(OP_ARRIVE, 1'b0, ID_W'($urandom), PRIO_W'($urandom),
                          CNT_W'($urandom));
      end
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        if (i % 25 == 0) begin
          case ($urandom_range(2))
            0: arrive_pct = 20;
            1: arrive_pct = 45;
            default: arrive_pct = 70;
          endcase
        end
        push_req(next_random_request());
      end
      drain_results();
    end

    repeat (20) @(posedge clk);
    if (mismatches == 0 && pending == 0) begin
      $display("watermark_gated_priority_dispatch_tb: PASS");
    end else begin
      $display("watermark_gated_priority_dispatch_tb: FAIL");
    end
    $finish;
  end

endmodule

// ===== watermark_gated_priority_dispatch.f =====
+incdir+hw/rtl
hw/rtl/wgpd_pkg.sv
hw/rtl/wgpd_cell.sv
hw/rtl/wgpd_queue.sv
hw/rtl/watermark_gated_priority_dispatch.sv
hw/rtl/wgpd_checker.sv
tb/sv/wgpd_dispatch_checker.sv
tb/sv/watermark_gated_priority_dispatch_tb.sv
